/* hdl/tla_pkg.sv */
// Shared types, constants and codes of the texture layer allocator.
`timescale 1ns / 1ps
package tla_pkg;

  localparam int TEXTURES_DEF = 256;
  localparam int LAYERS_DEF = 64;
  localparam int ALIGN_BYTES_DEF = 512;

  localparam logic [15:0] NULL_TEX_ID = 16'd1000;
  localparam logic [23:0] OFF_MAX = 24'hFFFFFF;
  localparam logic [16:0] PAL_DIRECT = 17'h1FFFF;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_ROW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_JOBS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd3;

  localparam logic [9:0] PAL_ROW_RST = 10'd0;
  localparam logic [23:0] CAPACITY_RST = 24'd4194304;
  localparam logic [7:0] MAX_JOBS_RST = 8'd64;
  localparam logic [15:0] MAX_ENTRIES_RST = 16'd16384;

  localparam logic [1:0] OP_BIND = 2'd0;
  localparam logic [1:0] OP_UNLOCK = 2'd1;
  localparam logic [1:0] OP_FRAME = 2'd2;

  localparam logic [2:0] ST_BOUND = 3'd0;
  localparam logic [2:0] ST_REPEAT = 3'd1;
  localparam logic [2:0] ST_BAD_HANDLE = 3'd2;
  localparam logic [2:0] ST_NO_SURFACE = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_ALIGN,
    S_DONE
  } state_t;

endpackage

/* hdl/tla_in_if.sv */
// Request channel of the texture layer allocator.
`timescale 1ns / 1ps
interface tla_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] texture_id;
  logic [15:0] palette_id;
  logic        has_surface;
  logic        is_indexed;
  logic [10:0] tex_width;
  logic [10:0] tex_height;

  modport source (
    output valid, op, texture_id, palette_id, has_surface, is_indexed, tex_width,
           tex_height,
    input  ready
  );
  modport sink (
    input  valid, op, texture_id, palette_id, has_surface, is_indexed, tex_width,
           tex_height,
    output ready
  );
endinterface

/* hdl/tla_out_if.sv */
// Result channel of the texture layer allocator.
`timescale 1ns / 1ps
interface tla_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [5:0]         layer;
  logic signed [16:0] palette_row;
  logic               upload_issued;
  logic [23:0]        upload_offset;
  logic               upload_dropped;

  modport source (
    output valid, status, layer, palette_row, upload_issued, upload_offset,
           upload_dropped,
    input  ready
  );
  modport sink (
    input  valid, status, layer, palette_row, upload_issued, upload_offset,
           upload_dropped,
    output ready
  );
endinterface

/* hdl/texture_layer_allocator_unit.sv */
// Texture layer allocator: free layer stack, per-texture layer map, staging space.
// Usage:
//   in_req carries bind (op 0), unlock (op 1) and frame start (op 2) requests;
//   every request gives exactly one result on out_res. Both channels move a
//   request when valid and ready are high at a rising clock edge.
//   cfg_we/cfg_index/cfg_wdata write the four limit registers; write them only
//   while no request is in flight.
// Timing:
//   One request at a time; its result appears as ready rises again. A bind past
//   the handle and surface checks and an unlock of a texture in range step
//   through S_READ (RAM read), S_EXEC (decision) and S_DONE (result load); other
//   requests skip S_EXEC. A bind that issues an upload adds S_ALIGN (a mask for a
//   power-of-two ALIGN_BYTES, otherwise a reciprocal multiply and a scale).
// Reset:
//   Synchronous, active low. All layers are free, no texture holds a layer,
//   counters are zero and the limit registers take their defaults. There is no
//   clearing pass; the block is ready as soon as reset is released.
// Back-pressure:
//   The result waits in the output register while out_res.ready is low; the
//   next request is still accepted and processed and holds in its last step.
`timescale 1ns / 1ps
module texture_layer_allocator_unit #(
  parameter int TEXTURES = tla_pkg::TEXTURES_DEF,
  parameter int LAYERS = tla_pkg::LAYERS_DEF,
  parameter int ALIGN_BYTES = tla_pkg::ALIGN_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tla_in_if.sink                          in_req,
  tla_out_if.source                       out_res,
  input  logic                            cfg_we,
  input  logic [tla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tla_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tla_pkg::*;

  localparam int IW = (TEXTURES > 1) ? $clog2(TEXTURES) : 1;
  localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int FCW = $clog2(LAYERS + 1);

  // configuration
  logic [9:0]  pal_row_cfg_r;
  logic [23:0] capacity_r;
  logic [7:0]  max_jobs_r;
  logic [15:0] max_entries_r;

  // request
  logic [1:0]  op_r;
  logic [15:0] tid_r;
  logic [15:0] pid_r;
  logic        surf_r;
  logic        indexed_r;
  logic [10:0] w_r;
  logic [10:0] h_r;
  logic [23:0] size_r;

  // allocator state
  state_t      state_r, state_nxt;
  logic [31:0] last_handle_r, last_handle_nxt;
  logic [15:0] ent_cnt_r, ent_cnt_nxt;
  logic [5:0]  last_layer_r, last_layer_nxt;
  logic [16:0] last_pal_r, last_pal_nxt;
  logic [FCW-1:0] fc_r, fc_nxt;
  logic [23:0] stage_off_r, stage_off_nxt;
  logic [7:0]  job_cnt_r, job_cnt_nxt;
  logic [TEXTURES-1:0] map_vld_r;
  logic [LAYERS-1:0]   stk_wr_r;

  // pending result and output register
  logic [2:0]  res_status_r, res_status_nxt;
  logic [5:0]  res_layer_r, res_layer_nxt;
  logic [16:0] res_pal_r, res_pal_nxt;
  logic        res_iss_r, res_iss_nxt;
  logic [23:0] res_off_r, res_off_nxt;
  logic        res_drop_r, res_drop_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_load;
  logic [2:0]  out_status_r;
  logic [5:0]  out_layer_r;
  logic [16:0] out_pal_r;
  logic        out_iss_r;
  logic [23:0] out_off_r;
  logic        out_drop_r;

  // datapath
  logic [15:0]    tid_use;
  logic [15:0]    idx_full;
  logic [IW-1:0]  idx;
  logic           bad_tid;
  logic [FCW-1:0] fc_dec;
  logic [LW-1:0]  pop_addr;
  logic [LW-1:0]  pop_layer;
  logic [LW-1:0]  map_rdata;
  logic [LW-1:0]  stk_rdata;
  logic [LW-1:0]  layer_v;
  logic [16:0]    pal_v;
  logic [24:0]    sum_v;
  logic           space_ok;
  logic           map_we;
  logic           map_set;
  logic           map_clr;
  logic           stk_we;
  logic           align_start;
  logic           align_done;
  logic [23:0]    align_result;

  always_comb begin
    tid_use = (op_r == OP_BIND && tid_r == 16'd0) ? NULL_TEX_ID : tid_r;
    bad_tid = (tid_use == 16'd0) || (tid_use > 16'(TEXTURES));
    idx_full = tid_use - 16'd1;
    idx = idx_full[IW-1:0];
    fc_dec = fc_r - 1'b1;
    pop_addr = fc_dec[LW-1:0];
    pop_layer = stk_wr_r[pop_addr] ? stk_rdata : pop_addr;
    sum_v = {1'b0, stage_off_r} + {1'b0, size_r};
    space_ok = (job_cnt_r < max_jobs_r) && (sum_v <= {1'b0, capacity_r});
    if (!indexed_r) begin
      pal_v = PAL_DIRECT;
    end else if (pid_r != 16'd0) begin
      pal_v = {1'b0, pid_r - 16'd1};
    end else begin
      pal_v = 17'(pal_row_cfg_r);
    end
  end

  tla_ram #(.WIDTH(LW), .DEPTH(TEXTURES)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (idx),
    .wdata (pop_layer),
    .raddr (idx),
    .rdata (map_rdata)
  );

  tla_ram #(.WIDTH(LW), .DEPTH(LAYERS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (fc_r[LW-1:0]),
    .wdata (map_rdata),
    .raddr (pop_addr),
    .rdata (stk_rdata)
  );

  tla_align #(.ALIGN_BYTES(ALIGN_BYTES)) u_align (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (align_start),
    .sum    (sum_v[23:0]),
    .done   (align_done),
    .result (align_result)
  );

  always_comb begin
    state_nxt = state_r;
    last_handle_nxt = last_handle_r;
    ent_cnt_nxt = ent_cnt_r;
    last_layer_nxt = last_layer_r;
    last_pal_nxt = last_pal_r;
    fc_nxt = fc_r;
    stage_off_nxt = stage_off_r;
    job_cnt_nxt = job_cnt_r;
    res_status_nxt = res_status_r;
    res_layer_nxt = res_layer_r;
    res_pal_nxt = res_pal_r;
    res_iss_nxt = res_iss_r;
    res_off_nxt = res_off_r;
    res_drop_nxt = res_drop_r;
    map_we = 1'b0;
    map_set = 1'b0;
    map_clr = 1'b0;
    stk_we = 1'b0;
    align_start = 1'b0;
    out_load = 1'b0;
    layer_v = '0;
    in_req.ready = (state_r == S_IDLE);
    out_valid_nxt = out_valid_r && !out_res.ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        res_status_nxt = ST_DONE;
        res_layer_nxt = '0;
        res_pal_nxt = '0;
        res_iss_nxt = 1'b0;
        res_off_nxt = '0;
        res_drop_nxt = 1'b0;
        state_nxt = S_DONE;
        unique case (op_r)
          OP_BIND: begin
            if ({pid_r, tid_use} == last_handle_r && ent_cnt_r != 16'd0) begin
              res_layer_nxt = last_layer_r;
              res_pal_nxt = last_pal_r;
              if (ent_cnt_r < max_entries_r) begin
                ent_cnt_nxt = ent_cnt_r + 16'd1;
                res_status_nxt = ST_REPEAT;
              end else begin
                res_status_nxt = ST_FULL;
              end
            end else begin
              last_handle_nxt = {pid_r, tid_use};
              if (bad_tid) begin
                res_status_nxt = ST_BAD_HANDLE;
              end else if (!surf_r) begin
                res_status_nxt = ST_NO_SURFACE;
              end else begin
                state_nxt = S_EXEC;
              end
            end
          end
          OP_UNLOCK: begin
            if (!bad_tid) begin
              state_nxt = S_EXEC;
            end
          end
          OP_FRAME: begin
            stage_off_nxt = '0;
            job_cnt_nxt = '0;
            ent_cnt_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        if (op_r == OP_UNLOCK) begin
          if (map_vld_r[idx]) begin
            if (fc_r < FCW'(LAYERS)) begin
              stk_we = 1'b1;
              fc_nxt = fc_r + 1'b1;
            end
            map_clr = 1'b1;
          end
        end else begin
          if (map_vld_r[idx]) begin
            layer_v = map_rdata;
          end else if (fc_r != '0) begin
            if (space_ok) begin
              layer_v = pop_layer;
              fc_nxt = fc_dec;
              job_cnt_nxt = job_cnt_r + 8'd1;
              map_we = 1'b1;
              map_set = 1'b1;
              align_start = 1'b1;
              res_iss_nxt = 1'b1;
              res_off_nxt = stage_off_r;
              state_nxt = S_ALIGN;
            end else begin
              res_drop_nxt = 1'b1;
            end
          end
          res_layer_nxt = 6'(layer_v);
          res_pal_nxt = pal_v;
          if (ent_cnt_r >= max_entries_r) begin
            res_status_nxt = ST_FULL;
          end else begin
            ent_cnt_nxt = ent_cnt_r + 16'd1;
            last_layer_nxt = 6'(layer_v);
            last_pal_nxt = pal_v;
            res_status_nxt = ST_BOUND;
          end
        end
      end
      S_ALIGN: begin
        if (align_done) begin
          stage_off_nxt = align_result;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_handle_r <= '0;
      ent_cnt_r <= '0;
      last_layer_r <= '0;
      last_pal_r <= '0;
      fc_r <= FCW'(LAYERS);
      stage_off_r <= '0;
      job_cnt_r <= '0;
      map_vld_r <= '0;
      stk_wr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_handle_r <= last_handle_nxt;
      ent_cnt_r <= ent_cnt_nxt;
      last_layer_r <= last_layer_nxt;
      last_pal_r <= last_pal_nxt;
      fc_r <= fc_nxt;
      stage_off_r <= stage_off_nxt;
      job_cnt_r <= job_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (map_set) begin
        map_vld_r[idx] <= 1'b1;
      end
      if (map_clr) begin
        map_vld_r[idx] <= 1'b0;
      end
      if (stk_we) begin
        stk_wr_r[fc_r[LW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_row_cfg_r <= PAL_ROW_RST;
      capacity_r <= CAPACITY_RST;
      max_jobs_r <= MAX_JOBS_RST;
      max_entries_r <= MAX_ENTRIES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAL_ROW:     pal_row_cfg_r <= cfg_wdata[9:0];
        CFG_CAPACITY:    capacity_r <= cfg_wdata[23:0];
        CFG_MAX_JOBS:    max_jobs_r <= cfg_wdata[7:0];
        CFG_MAX_ENTRIES: max_entries_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      op_r <= in_req.op;
      tid_r <= in_req.texture_id;
      pid_r <= in_req.palette_id;
      surf_r <= in_req.has_surface;
      indexed_r <= in_req.is_indexed;
      w_r <= in_req.tex_width;
      h_r <= in_req.tex_height;
    end
    if (state_r == S_READ) begin
      size_r <= {22'(w_r) * 22'(h_r), 2'b00};
    end
    res_status_r <= res_status_nxt;
    res_layer_r <= res_layer_nxt;
    res_pal_r <= res_pal_nxt;
    res_iss_r <= res_iss_nxt;
    res_off_r <= res_off_nxt;
    res_drop_r <= res_drop_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_layer_r <= res_layer_r;
      out_pal_r <= res_pal_r;
      out_iss_r <= res_iss_r;
      out_off_r <= res_off_r;
      out_drop_r <= res_drop_r;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.status = out_status_r;
  assign out_res.layer = out_layer_r;
  assign out_res.palette_row = out_pal_r;
  assign out_res.upload_issued = out_iss_r;
  assign out_res.upload_offset = out_off_r;
  assign out_res.upload_dropped = out_drop_r;

endmodule

/* hdl/tla_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/tla_align.sv */
// Round-up of a staging offset to the alignment by masking or reciprocal multiply, saturating.
`timescale 1ns / 1ps
module tla_align #(
  parameter int ALIGN_BYTES = tla_pkg::ALIGN_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] sum,
  output logic        done,
  output logic [23:0] result
);
  import tla_pkg::*;

  localparam int VW = 25;
  localparam int MW = 27;
  localparam int PW = VW + MW;
  localparam int AL = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 0;
  localparam int SH = VW + AL;
  localparam bit POW2 = ((ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0);
  localparam logic [VW-1:0] MASK = VW'(ALIGN_BYTES - 1);
  localparam longint unsigned RECIP_L =
    ((64'd1 << SH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
  localparam logic [VW-1:0] ALIGN_V = VW'(ALIGN_BYTES);

  logic [VW-1:0] val_r;
  logic [VW-1:0] quo_r;
  logic          fin1_r;
  logic          fin2_r;
  logic [PW-1:0] prod;
  logic [PW-1:0] prod_sh;
  logic [VW-1:0] rounded;

  // floor(val / ALIGN_BYTES) is exact for any 25-bit val with this reciprocal
  always_comb begin
    prod = PW'(val_r) * PW'(RECIP);
    prod_sh = prod >> SH;
    rounded = POW2 ? (val_r & ~MASK) : (quo_r * ALIGN_V);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin1_r <= 1'b0;
      fin2_r <= 1'b0;
    end else begin
      fin1_r <= start;
      fin2_r <= fin1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= {1'b0, sum} + MASK;
    end
    if (fin1_r) begin
      quo_r <= prod_sh[VW-1:0];
    end
  end

  assign done = POW2 ? fin1_r : fin2_r;
  assign result = rounded[VW-1] ? OFF_MAX : rounded[23:0];

endmodule

/* tb/tb.sv */
// Self-checking testbench for texture_layer_allocator_unit: predictor scoreboard and random traffic.
`timescale 1ns / 1ps

typedef struct packed {
  logic [1:0]  op;
  logic [15:0] texture_id;
  logic [15:0] palette_id;
  logic        has_surface;
  logic        is_indexed;
  logic [10:0] tex_width;
  logic [10:0] tex_height;
} tla_req_t;

typedef struct packed {
  logic [2:0]  status;
  logic [5:0]  layer;
  logic [16:0] palette_row;
  logic        upload_issued;
  logic [23:0] upload_offset;
  logic        upload_dropped;
} tla_res_t;

class layer_alloc_scoreboard;
  localparam int NUM_TEX = tla_pkg::TEXTURES_DEF;
  localparam int NUM_LAYERS = tla_pkg::LAYERS_DEF;
  localparam int ALIGN = tla_pkg::ALIGN_BYTES_DEF;

  logic [9:0]  pal_row;
  logic [23:0] capacity;
  logic [7:0]  max_jobs;
  logic [15:0] max_entries;

  logic [31:0] last_handle;
  logic [15:0] entry_count;
  logic [5:0]  last_entry_layer;
  logic [16:0] last_entry_pal;
  bit          map_valid[NUM_TEX];
  logic [5:0]  layer_map[NUM_TEX];
  logic [5:0]  free_stack[NUM_LAYERS];
  int          free_count;
  logic [23:0] staging_offset;
  logic [7:0]  job_count;

  tla_res_t    expected_q[$];
  int          errors;

  function new();
    pal_row = tla_pkg::PAL_ROW_RST;
    capacity = tla_pkg::CAPACITY_RST;
    max_jobs = tla_pkg::MAX_JOBS_RST;
    max_entries = tla_pkg::MAX_ENTRIES_RST;
    last_handle = '0;
    entry_count = '0;
    last_entry_layer = '0;
    last_entry_pal = '0;
    for (int i = 0; i < NUM_TEX; i++) begin
      map_valid[i] = 1'b0;
      layer_map[i] = '0;
    end
    for (int i = 0; i < NUM_LAYERS; i++) free_stack[i] = i[5:0];
    free_count = NUM_LAYERS;
    staging_offset = '0;
    job_count = '0;
    errors = 0;
  endfunction

  function void write_register(logic [1:0] idx, logic [23:0] val);
    case (idx)
      tla_pkg::CFG_PAL_ROW:     pal_row = val[9:0];
      tla_pkg::CFG_CAPACITY:    capacity = val;
      tla_pkg::CFG_MAX_JOBS:    max_jobs = val[7:0];
      tla_pkg::CFG_MAX_ENTRIES: max_entries = val[15:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void note_request(tla_req_t r);
    tla_res_t    res;
    logic [15:0] tid;
    logic [31:0] handle;
    logic [63:0] need_bytes;
    logic [63:0] aligned_end;
    logic [5:0]  layer;
    logic [16:0] pal;
    bit          have;
    int          idx;
    res = '0;
    res.status = tla_pkg::ST_DONE;
    case (r.op)
      tla_pkg::OP_BIND: begin
        tid = (r.texture_id == 16'd0) ? tla_pkg::NULL_TEX_ID : r.texture_id;
        handle = {r.palette_id, tid};
        if (handle == last_handle && entry_count != 16'd0) begin
          res.layer = last_entry_layer;
          res.palette_row = last_entry_pal;
          if (entry_count < max_entries) begin
            entry_count = entry_count + 16'd1;
            res.status = tla_pkg::ST_REPEAT;
          end else begin
            res.status = tla_pkg::ST_FULL;
          end
        end else begin
          last_handle = handle;
          if (tid < 16'd1 || tid > NUM_TEX) begin
            res.status = tla_pkg::ST_BAD_HANDLE;
          end else if (!r.has_surface) begin
            res.status = tla_pkg::ST_NO_SURFACE;
          end else begin
            idx = int'(tid) - 1;
            have = 1'b0;
            layer = '0;
            if (map_valid[idx]) begin
              layer = layer_map[idx];
              have = 1'b1;
            end else if (free_count > 0) begin
              need_bytes = 64'(r.tex_width) * 64'(r.tex_height) * 64'd4;
              free_count--;
              layer = free_stack[free_count];
              if (job_count < max_jobs &&
                  64'(staging_offset) + need_bytes <= 64'(capacity)) begin
                aligned_end = (64'(staging_offset) + need_bytes + 64'(ALIGN - 1)) /
                              64'(ALIGN) * 64'(ALIGN);
                res.upload_issued = 1'b1;
                res.upload_offset = staging_offset;
                staging_offset = (aligned_end > 64'(tla_pkg::OFF_MAX)) ? tla_pkg::OFF_MAX :
                                 aligned_end[23:0];
                job_count = job_count + 8'd1;
                layer_map[idx] = layer;
                map_valid[idx] = 1'b1;
                have = 1'b1;
              end else begin
                res.upload_dropped = 1'b1;
                free_stack[free_count] = layer;
                free_count++;
              end
            end
            if (!have) layer = '0;
            if (!r.is_indexed) pal = tla_pkg::PAL_DIRECT;
            else if (r.palette_id != 16'd0) pal = {1'b0, r.palette_id - 16'd1};
            else pal = {7'd0, pal_row};
            res.layer = layer;
            res.palette_row = pal;
            if (entry_count >= max_entries) begin
              res.status = tla_pkg::ST_FULL;
            end else begin
              entry_count = entry_count + 16'd1;
              last_entry_layer = layer;
              last_entry_pal = pal;
              res.status = tla_pkg::ST_BOUND;
            end
          end
        end
      end
      tla_pkg::OP_UNLOCK: begin
        if (r.texture_id >= 16'd1 && r.texture_id <= NUM_TEX) begin
          idx = int'(r.texture_id) - 1;
          if (map_valid[idx]) begin
            if (free_count < NUM_LAYERS) begin
              free_stack[free_count] = layer_map[idx];
              free_count++;
            end
            map_valid[idx] = 1'b0;
            layer_map[idx] = '0;
          end
        end
      end
      tla_pkg::OP_FRAME: begin
        staging_offset = '0;
        job_count = '0;
        entry_count = '0;
      end
      default: ;
    endcase
    expected_q.push_back(res);
  endfunction

  task report(string msg);
    if (errors < 100) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task check_result(tla_res_t got);
    tla_res_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("result with no request pending: %h", got));
    end else begin
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.layer !== want.layer)
        report($sformatf("layer %0d, want %0d", got.layer, want.layer));
      if (got.palette_row !== want.palette_row)
        report($sformatf("palette_row %h, want %h", got.palette_row, want.palette_row));
      if (got.upload_issued !== want.upload_issued)
        report($sformatf("upload_issued %b, want %b", got.upload_issued, want.upload_issued));
      if (got.upload_offset !== want.upload_offset)
        report($sformatf("upload_offset %h, want %h", got.upload_offset, want.upload_offset));
      if (got.upload_dropped !== want.upload_dropped)
        report($sformatf("upload_dropped %b, want %b", got.upload_dropped,
                         want.upload_dropped));
    end
  endtask
endclass

module tb;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SENDER = 0;
  localparam int RECEIVER = 1;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 108;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [tla_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tla_pkg::CFG_DATA_W-1:0] cfg_wdata;

  tla_in_if  in_req();
  tla_out_if out_res();

  texture_layer_allocator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  layer_alloc_scoreboard sb;
  int calm_left[2];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("texture_layer_allocator_unit: mismatch");
    $finish;
  end

  // per-request wait; occasional stretches of back-to-back traffic
  function automatic int draw_gap(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left[side] = int'($urandom_range(10, 40));
      return 0;
    end
    return int'($urandom_range(0, 13));
  endfunction

  function automatic tla_req_t make_req(logic [1:0] op, logic [15:0] tid, logic [15:0] pid,
                                        logic surf, logic indexed, logic [10:0] w,
                                        logic [10:0] h);
    tla_req_t r;
    r.op = op;
    r.texture_id = tid;
    r.palette_id = pid;
    r.has_surface = surf;
    r.is_indexed = indexed;
    r.tex_width = w;
    r.tex_height = h;
    return r;
  endfunction

  task automatic send_request(tla_req_t r);
    int gap;
    gap = draw_gap(SENDER);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.op <= r.op;
    in_req.texture_id <= r.texture_id;
    in_req.palette_id <= r.palette_id;
    in_req.has_surface <= r.has_surface;
    in_req.is_indexed <= r.is_indexed;
    in_req.tex_width <= r.tex_width;
    in_req.tex_height <= r.tex_height;
    in_req.valid <= 1'b1;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic drain_results();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_register(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : result_sink
    tla_res_t got;
    int stall;
    out_res.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_gap(RECEIVER);
      if (stall > 0) begin
        out_res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_res.ready <= 1'b1;
      @(posedge clk);
      while (!out_res.valid) @(posedge clk);
      got.status = out_res.status;
      got.layer = out_res.layer;
      got.palette_row = out_res.palette_row;
      got.upload_issued = out_res.upload_issued;
      got.upload_offset = out_res.upload_offset;
      got.upload_dropped = out_res.upload_dropped;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    tla_req_t r;
    tla_req_t prev_bind;
    bit have_prev;
    int pool;
    int roll;
    int wait_cycles;
    logic [23:0] val;

    sb = new();
    calm_left[SENDER] = 0;
    calm_left[RECEIVER] = 0;
    have_prev = 1'b0;
    prev_bind = '0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_req.valid = 1'b0;
    in_req.op = tla_pkg::OP_BIND;
    in_req.texture_id = '0;
    in_req.palette_id = '0;
    in_req.has_surface = 1'b0;
    in_req.is_indexed = 1'b0;
    in_req.tex_width = '0;
    in_req.tex_height = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // default limits: handle checks, repeat, drop, direct color, unlock corners
    send_request(make_req(tla_pkg::OP_BIND, 16'd0, 16'd0, 1'b1, 1'b1, 11'd1, 11'd1));
    send_request(make_req(tla_pkg::OP_BIND, 16'd0, 16'd0, 1'b1, 1'b1, 11'd1, 11'd1));
    send_request(make_req(tla_pkg::OP_BIND, 16'd257, 16'd7, 1'b1, 1'b0, 11'd2, 11'd2));
    send_request(make_req(tla_pkg::OP_BIND, 16'd5, 16'd0, 1'b0, 1'b1, 11'd4, 11'd4));
    send_request(make_req(tla_pkg::OP_BIND, 16'd1, 16'd0, 1'b1, 1'b1, 11'd1, 11'd1));
    send_request(make_req(tla_pkg::OP_BIND, 16'd1, 16'd0, 1'b1, 1'b1, 11'd1, 11'd1));
    send_request(make_req(tla_pkg::OP_BIND, 16'd256, 16'hFFFF, 1'b1, 1'b1, 11'd1024,
                          11'd1024));
    send_request(make_req(tla_pkg::OP_BIND, 16'd2, 16'd3, 1'b1, 1'b0, 11'd0, 11'd0));
    send_request(make_req(tla_pkg::OP_BIND, 16'd1, 16'd0, 1'b1, 1'b1, 11'd9, 11'd9));
    send_request(make_req(tla_pkg::OP_UNLOCK, 16'd1, 16'd0, 1'b0, 1'b0, 11'd0, 11'd0));
    send_request(make_req(tla_pkg::OP_UNLOCK, 16'd1, 16'd0, 1'b0, 1'b0, 11'd0, 11'd0));
    send_request(make_req(tla_pkg::OP_UNLOCK, 16'd0, 16'd0, 1'b1, 1'b1, 11'd0, 11'd0));
    send_request(make_req(tla_pkg::OP_UNLOCK, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 11'd1024,
                          11'd1024));
    send_request(make_req(OP_UNUSED, 16'd2, 16'h1234, 1'b1, 1'b1, 11'd3, 11'd5));
    send_request(make_req(tla_pkg::OP_FRAME, 16'd0, 16'd0, 1'b0, 1'b0, 11'd0, 11'd0));
    send_request(make_req(tla_pkg::OP_BIND, 16'd3, 16'd0, 1'b1, 1'b0, 11'd1024, 11'd1024));
    send_request(make_req(tla_pkg::OP_BIND, 16'd4, 16'd0, 1'b1, 1'b0, 11'd1, 11'd1));
    send_request(make_req(tla_pkg::OP_FRAME, 16'd0, 16'd0, 1'b0, 1'b0, 11'd0, 11'd0));
    send_request(make_req(tla_pkg::OP_BIND, 16'd1, 16'd1, 1'b1, 1'b1, 11'd1024, 11'd1));

    // staging offset saturation, entry limit and repeat while full
    drain_results();
    write_register(tla_pkg::CFG_PAL_ROW, 24'd1023);
    write_register(tla_pkg::CFG_CAPACITY, tla_pkg::OFF_MAX);
    write_register(tla_pkg::CFG_MAX_JOBS, 24'd255);
    write_register(tla_pkg::CFG_MAX_ENTRIES, 24'd3);
    send_request(make_req(tla_pkg::OP_FRAME, 16'd0, 16'd0, 1'b0, 1'b0, 11'd0, 11'd0));
    send_request(make_req(tla_pkg::OP_BIND, 16'd20, 16'd0, 1'b1, 1'b1, 11'd1024, 11'd1024));
    send_request(make_req(tla_pkg::OP_BIND, 16'd21, 16'd0, 1'b1, 1'b1, 11'd1024, 11'd1024));
    send_request(make_req(tla_pkg::OP_BIND, 16'd22, 16'd0, 1'b1, 1'b1, 11'd1024, 11'd1024));
    send_request(make_req(tla_pkg::OP_BIND, 16'd23, 16'd0, 1'b1, 1'b1, 11'd1024, 11'd1023));
    send_request(make_req(tla_pkg::OP_BIND, 16'd24, 16'd0, 1'b1, 1'b1, 11'd32, 11'd28));
    send_request(make_req(tla_pkg::OP_BIND, 16'd25, 16'd0, 1'b1, 1'b1, 11'd1, 11'd1));
    send_request(make_req(tla_pkg::OP_BIND, 16'd25, 16'd0, 1'b1, 1'b1, 11'd1, 11'd1));
    send_request(make_req(tla_pkg::OP_BIND, 16'd26, 16'd0, 1'b1, 1'b0, 11'd1, 11'd1));

    // zero limits
    drain_results();
    write_register(tla_pkg::CFG_PAL_ROW, 24'd0);
    write_register(tla_pkg::CFG_CAPACITY, 24'd0);
    write_register(tla_pkg::CFG_MAX_JOBS, 24'd0);
    write_register(tla_pkg::CFG_MAX_ENTRIES, 24'd0);
    send_request(make_req(tla_pkg::OP_BIND, 16'd30, 16'd0, 1'b1, 1'b1, 11'd0, 11'd0));
    send_request(make_req(tla_pkg::OP_BIND, 16'd20, 16'd0, 1'b1, 1'b1, 11'd1, 11'd1));
    send_request(make_req(tla_pkg::OP_BIND, 16'd20, 16'd0, 1'b1, 1'b1, 11'd1, 11'd1));

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      roll = $urandom_range(0, 3);
      val = (roll == 0) ? 24'd0 : (roll == 1) ? 24'd1023 : 24'($urandom_range(0, 1023));
      write_register(tla_pkg::CFG_PAL_ROW, val);
      roll = $urandom_range(0, 6);
      case (roll)
        0: val = 24'd0;
        1: val = tla_pkg::OFF_MAX;
        2: val = 24'($urandom_range(2048, 65536));
        3: val = 24'($urandom_range(0, 24'hFFFFFF));
        default: val = tla_pkg::CAPACITY_RST;
      endcase
      write_register(tla_pkg::CFG_CAPACITY, val);
      roll = $urandom_range(0, 6);
      case (roll)
        0: val = 24'd0;
        1: val = 24'd255;
        2: val = 24'($urandom_range(1, 16));
        default: val = 24'(tla_pkg::MAX_JOBS_RST);
      endcase
      write_register(tla_pkg::CFG_MAX_JOBS, val);
      roll = $urandom_range(0, 6);
      case (roll)
        0: val = 24'd0;
        1: val = 24'd65535;
        2: val = 24'($urandom_range(1, 40));
        default: val = 24'(tla_pkg::MAX_ENTRIES_RST);
      endcase
      write_register(tla_pkg::CFG_MAX_ENTRIES, val);
      roll = $urandom_range(0, 2);
      pool = (roll == 0) ? 8 : (roll == 1) ? 32 : 256;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (have_prev && $urandom_range(0, 99) < 8) begin
          r = prev_bind;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 68) r.op = tla_pkg::OP_BIND;
          else if (roll < 84) r.op = tla_pkg::OP_UNLOCK;
          else if (roll < 96) r.op = tla_pkg::OP_FRAME;
          else r.op = OP_UNUSED;
          roll = $urandom_range(0, 99);
          if (roll < 88) r.texture_id = 16'($urandom_range(1, pool));
          else if (roll < 94) r.texture_id = 16'd0;
          else r.texture_id = 16'($urandom_range(257, 65535));
          roll = $urandom_range(0, 99);
          if (roll < 40) r.palette_id = 16'd0;
          else if (roll < 80) r.palette_id = 16'($urandom_range(1, 8));
          else r.palette_id = 16'($urandom_range(0, 65535));
          r.has_surface = ($urandom_range(0, 9) != 0);
          r.is_indexed = 1'($urandom_range(0, 1));
          roll = $urandom_range(0, 99);
          if (roll < 85) begin
            r.tex_width = 11'($urandom_range(0, 64));
            r.tex_height = 11'($urandom_range(0, 64));
          end else if (roll < 97) begin
            r.tex_width = 11'($urandom_range(0, 1024));
            r.tex_height = 11'($urandom_range(0, 1024));
          end else begin
            r.tex_width = 11'd1024;
            r.tex_height = 11'd1024;
          end
        end
        if (r.op == tla_pkg::OP_BIND) begin
          prev_bind = r;
          have_prev = 1'b1;
        end
        send_request(r);
      end
    end

    in_req.valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 4000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("texture_layer_allocator_unit: match");
    end else begin
      $display("texture_layer_allocator_unit: mismatch");
    end
    $finish;
  end
endmodule
